// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLY(label, clk, rstn, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (expr)) \
    else $error("assertion failed: same-cycle implication");

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/s2a_pkg.sv -----
package s2a_pkg;

  // Character store geometry
  localparam int unsigned FifoDepth = 256;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned LvlW      = $clog2(FifoDepth + 1);

  // Field widths
  localparam int unsigned CharW  = 7;
  localparam int unsigned ScanW  = 8;
  localparam int unsigned LevelW = 9;

  // Command queue between decoder and character store
  localparam int unsigned CmdqDepth = 2;
  localparam int unsigned CmdqIdxW  = $clog2(CmdqDepth);
  localparam int unsigned CmdqCntW  = $clog2(CmdqDepth + 1);

  // Opcodes
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Make codes with special handling
  localparam logic [6:0] KEY_ESC    = 7'h01;
  localparam logic [6:0] KEY_BKSP   = 7'h0E;
  localparam logic [6:0] KEY_TAB    = 7'h0F;
  localparam logic [6:0] KEY_ENTER  = 7'h1C;
  localparam logic [6:0] KEY_CTRL   = 7'h1D;
  localparam logic [6:0] KEY_LSHIFT = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT = 7'h36;
  localparam logic [6:0] KEY_ALT    = 7'h38;
  localparam logic [6:0] KEY_SPACE  = 7'h39;
  localparam logic [6:0] KEY_CAPS   = 7'h3A;

  // Fixed character codes
  localparam logic [CharW-1:0] CH_LF  = 7'h0A;
  localparam logic [CharW-1:0] CH_BS  = 7'h08;
  localparam logic [CharW-1:0] CH_SP  = 7'h20;
  localparam logic [CharW-1:0] CH_TAB = 7'h09;
  localparam logic [CharW-1:0] CH_ESC = 7'h1B;
  localparam logic [CharW-1:0] CaseDelta = 7'h20;

  localparam logic [CharW-1:0] BaseMap [64] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h00, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [CharW-1:0] UpperMap [64] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h00, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_PUSH,
    CMD_POP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [CharW-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic             opcode;
    logic [ScanW-1:0] scan_byte;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0]  char_out;
    logic              char_valid;
    logic [LevelW-1:0] fifo_level;
  } out_item_t;

  // Translate a make code to a character, 0 when the key has none
  function automatic logic [CharW-1:0] key_to_char(logic [6:0] code, logic shifted,
                                                   logic caps);
    logic [CharW-1:0] b;
    logic [CharW-1:0] u;
    logic [CharW-1:0] r;
    b = BaseMap[code[5:0]];
    u = UpperMap[code[5:0]];
    r = b;
    case (code)
      KEY_ENTER: r = CH_LF;
      KEY_BKSP:  r = CH_BS;
      KEY_SPACE: r = CH_SP;
      KEY_TAB:   r = CH_TAB;
      KEY_ESC:   r = CH_ESC;
      default: begin
        if (code[6]) begin
          r = '0;
        end else if (b inside {[7'h61:7'h7A]}) begin
          r = (shifted != caps) ? (b - CaseDelta) : b;
        end else if (shifted && (u != '0)) begin
          r = u;
        end
      end
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/s2a_ram.sv -----
module s2a_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/s2a_front.sv -----
module s2a_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  s2a_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output s2a_pkg::cmd_t     q_cmd_o
);
  import s2a_pkg::*;

  logic       lshift_q, lshift_d;
  logic       rshift_q, rshift_d;
  logic       caps_q, caps_d;
  logic       press;
  logic [6:0] code;
  logic [CharW-1:0] mapped;
  logic       accept;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept;

  assign press  = !in_item_i.scan_byte[7];
  assign code   = in_item_i.scan_byte[6:0];
  assign mapped = key_to_char(code, lshift_q || rshift_q, caps_q);

  // Classify the item and update modifier state
  always_comb begin
    lshift_d     = lshift_q;
    rshift_d     = rshift_q;
    caps_d       = caps_q;
    q_cmd_o.kind = CMD_NOP;
    q_cmd_o.ch   = '0;
    if (in_item_i.opcode == OP_POP) begin
      q_cmd_o.kind = CMD_POP;
    end else begin
      case (code)
        KEY_LSHIFT: lshift_d = press;
        KEY_RSHIFT: rshift_d = press;
        KEY_CAPS: begin
          if (press) begin
            caps_d = !caps_q;
          end
        end
        KEY_CTRL, KEY_ALT: begin
        end
        default: begin
          if (press && (mapped != '0)) begin
            q_cmd_o.kind = CMD_PUSH;
            q_cmd_o.ch   = mapped;
          end
        end
      endcase
    end
  end

  // Commit modifier state on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lshift_q <= 1'b0;
      rshift_q <= 1'b0;
      caps_q   <= 1'b0;
    end else if (accept) begin
      lshift_q <= lshift_d;
      rshift_q <= rshift_d;
      caps_q   <= caps_d;
    end
  end

endmodule

// ----- rtl/s2a_cmdq.sv -----
module s2a_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  s2a_pkg::cmd_t cmd_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output s2a_pkg::cmd_t cmd_o
);
  import s2a_pkg::*;

  cmd_t                slot_q [CmdqDepth];
  logic [CmdqIdxW-1:0] wr_idx_q, wr_idx_d;
  logic [CmdqIdxW-1:0] rd_idx_q, rd_idx_d;
  logic [CmdqCntW-1:0] cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (cnt_q == CmdqCntW'(CmdqDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_idx_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance indices and count
  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_idx_d = (wr_idx_q == CmdqIdxW'(CmdqDepth - 1)) ? '0 : wr_idx_q + 1'b1;
    end
    if (do_pop) begin
      rd_idx_d = (rd_idx_q == CmdqIdxW'(CmdqDepth - 1)) ? '0 : rd_idx_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_idx_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/s2a_back.sv -----
module s2a_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  s2a_pkg::cmd_t      q_cmd_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output s2a_pkg::out_item_t out_item_o
);
  import s2a_pkg::*;

  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0]  level_q, level_d;
  logic             out_valid_q, out_valid_d;
  logic             cvalid_q, cvalid_d;
  logic [LvlW-1:0]  out_level_q;
  logic             adv;
  logic             take;
  logic             ram_we;
  logic             ram_re;
  logic [CharW-1:0] ram_rdata;

  // Take a command when the output register is free or being drained
  assign adv     = !out_valid_q || !out_stall_i;
  assign take    = adv && q_valid_i;
  assign q_pop_o = take;

  // Update pointers and level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    cvalid_d = 1'b0;
    if (take) begin
      case (q_cmd_i.kind)
        CMD_PUSH: begin
          ram_we   = 1'b1;
          wr_ptr_d = (wr_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
          if (level_q == LvlW'(FifoDepth)) begin
            // drop the oldest character
            rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
          end else begin
            level_d = level_q + 1'b1;
          end
        end
        CMD_POP: begin
          if (level_q != '0) begin
            ram_re   = 1'b1;
            cvalid_d = 1'b1;
            rd_ptr_d = (rd_ptr_q == PtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
            level_d  = level_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_d = take || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the result register on each taken command
  always_ff @(posedge clk_i) begin
    if (take) begin
      cvalid_q    <= cvalid_d;
      out_level_q <= level_d;
    end
  end

  s2a_ram #(
    .Width(CharW),
    .Depth(FifoDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_ptr_q),
    .wdata_i(q_cmd_i.ch),
    .re_i   (ram_re),
    .raddr_i(rd_ptr_q),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o           = out_valid_q;
  assign out_item_o.char_out   = cvalid_q ? ram_rdata : '0;
  assign out_item_o.char_valid = cvalid_q;
  assign out_item_o.fifo_level = LevelW'(out_level_q);

endmodule

// ----- rtl/scancode_to_ascii_fifo_core.sv -----
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_stall_o  in_item_i  (opcode, scan_byte)
// out       output     out_valid_o / out_stall_i out_item_o (char_out, char_valid, fifo_level)
//
// One item per cycle sustained while the output is not stalled; each item gives one result.
// Each item passes through the decoder-to-store command queue and the registered read of
// the character RAM, whose read register drives char_out, gated by the pop's valid flag.
// The two-entry command queue absorbs a stalled output while the decoder keeps taking items until it fills.
// Reset clears modifier state, pointers and level; the character RAM is not cleared.
module scancode_to_ascii_fifo_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  s2a_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output s2a_pkg::out_item_t out_item_o
);
  import s2a_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_cmd_in;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd_out;

  // Decode scancodes and track modifiers
  s2a_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_cmd_o   (q_cmd_in)
  );

  // Buffer commands between decoder and store
  s2a_cmdq u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd_in),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .cmd_o  (q_cmd_out)
  );

  // Execute pushes and pops on the character store
  s2a_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd_out),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

// ----- rtl/s2a_checker.sv -----
`include "assert_macros.svh"

module s2a_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input s2a_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input s2a_pkg::out_item_t out_item_o
);
  import s2a_pkg::*;

  // Hold a stalled input transfer
  `ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i && $stable(in_item_i))

  // Hold a stalled result
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

  // A popped character is never zero
  `ASSERT_IMPLY(a_char_nonzero, clk_i, rst_ni, out_valid_o && out_item_o.char_valid, out_item_o.char_out != '0)

  // No character without a valid pop
  `ASSERT_IMPLY(a_char_zero, clk_i, rst_ni, out_valid_o && !out_item_o.char_valid, out_item_o.char_out == '0)

  // Level never exceeds the store depth
  `ASSERT_IMPLY(a_level_max, clk_i, rst_ni, out_valid_o, out_item_o.fifo_level <= LevelW'(FifoDepth))

endmodule

bind scancode_to_ascii_fifo_core s2a_checker u_s2a_checker (.*);
